/* design/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* design/wcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wcp_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 32;

  localparam logic [31:0] ID_RIFF   = 32'h4646_4952;
  localparam logic [31:0] TYPE_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT    = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA   = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_NO_RIFF  = 2'd2;
  localparam logic [1:0] ST_NOT_WAVE = 2'd3;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 200;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last;
  } wcp_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] format_tag;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] avg_bytes_per_sec;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } wcp_result_t;

endpackage

`default_nettype wire

/* design/wcp_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module wcp_in_stage (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [wcp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [7:0] file_byte
  input  wire logic                                 s_axis_tlast,
  input  wire logic                                 out_free_i,
  output logic                                      item_valid_o,
  output wcp_pkg::wcp_item_t                        item_o
);

  logic               valid_q, valid_d;
  wcp_pkg::wcp_item_t item_q;
  logic               advance;
  logic               accept;

  // a final byte needs the result register free; any other byte always moves on
  assign advance       = valid_q && (!item_q.last || out_free_i);
  assign s_axis_tready = !valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.file_byte <= s_axis_tdata[7:0];
      item_q.last      <= s_axis_tlast;
    end
  end

  assign item_valid_o = advance;
  assign item_o       = item_q;

endmodule

`default_nettype wire

/* design/wcp_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wcp_parser #(
  parameter int unsigned POSITION_WIDTH = wcp_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  input  wire wcp_pkg::wcp_item_t  item_i,
  output logic                     result_valid_o,
  output wcp_pkg::wcp_result_t     result_o
);

  localparam logic [2:0] PH_RIFF   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_FMT    = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  logic [2:0]                phase_q, phase_d;
  logic [3:0]                cnt_q, cnt_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [31:0]               skip_q, skip_d;
  logic [31:0]               id_q, id_d;
  logic [31:0]               size_q, size_d;
  logic [63:0]               fmt_fields_q, fmt_fields_d;  // tag, channels, align, bits
  logic [63:0]               fmt_rates_q, fmt_rates_d;    // rate, byte rate
  logic [63:0]               data_info_q, data_info_d;    // offset low, size high
  logic [1:0]                err_q, err_d;
  logic [1:0]                status;
  logic [2:0]                field_lane;
  logic [2:0]                rate_lane;

  function automatic logic [31:0] set_lane(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[8*lane +: 8] = b;
    return w;
  endfunction

  assign field_lane = {cnt_q[3], cnt_q[1:0]};
  assign rate_lane  = 3'(cnt_q - 4'd4);

  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    skip_d       = skip_q;
    id_d         = id_q;
    size_d       = size_q;
    fmt_fields_d = fmt_fields_q;
    fmt_rates_d  = fmt_rates_q;
    data_info_d  = data_info_q;
    err_d        = err_q;
    status       = wcp_pkg::ST_OK;
    result_o     = '0;

    if (item_valid_i) begin
      pos_d = (pos_q == '1) ? pos_q : pos_q + 1'b1;

      case (phase_q)
        PH_RIFF: begin
          if (cnt_q < 4'd4) begin
            id_d = set_lane(id_q, cnt_q[1:0], item_i.file_byte);
          end else if (cnt_q >= 4'd8) begin
            size_d = set_lane(size_q, cnt_q[1:0], item_i.file_byte);
          end
          if (cnt_q == 4'd11) begin
            if (id_d != wcp_pkg::ID_RIFF) begin
              err_d   = wcp_pkg::ST_NO_RIFF;
              phase_d = PH_ERROR;
            end else if (size_d != wcp_pkg::TYPE_WAVE) begin
              err_d   = wcp_pkg::ST_NOT_WAVE;
              phase_d = PH_ERROR;
            end else begin
              phase_d = PH_HEADER;
            end
            cnt_d = '0;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_HEADER: begin
          if (cnt_q < 4'd4) begin
            id_d = set_lane(id_q, cnt_q[1:0], item_i.file_byte);
          end else begin
            size_d = set_lane(size_q, cnt_q[1:0], item_i.file_byte);
          end
          if (cnt_q >= 4'd7) begin
            cnt_d = '0;
            if (id_d == wcp_pkg::ID_FMT) begin
              fmt_fields_d = '0;
              fmt_rates_d  = '0;
              skip_d       = (size_d > wcp_pkg::FMT_BODY_LEN) ?
                             size_d - wcp_pkg::FMT_BODY_LEN : '0;
              phase_d      = PH_FMT;
            end else begin
              if (id_d == wcp_pkg::ID_DATA) begin
                data_info_d = {size_d, 32'(pos_d)};
              end
              skip_d  = size_d;
              phase_d = (size_d != '0) ? PH_SKIP : PH_HEADER;
            end
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_FMT: begin
          if (cnt_q < 4'd4 || cnt_q >= 4'd12) begin
            fmt_fields_d[8*field_lane +: 8] = item_i.file_byte;
          end else begin
            fmt_rates_d[8*rate_lane +: 8] = item_i.file_byte;
          end
          if (cnt_q == 4'd15) begin
            cnt_d   = '0;
            phase_d = (skip_q != '0) ? PH_SKIP : PH_HEADER;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_SKIP: begin
          if (skip_q != '0) begin
            skip_d = skip_q - 32'd1;
          end
          if (skip_d == '0) begin
            cnt_d   = '0;
            phase_d = PH_HEADER;
          end
        end
        default: begin
        end
      endcase

      if (item_i.last) begin
        status = (phase_d == PH_RIFF) ? wcp_pkg::ST_SHORT : err_d;
        result_o.status = status;
        if (status == wcp_pkg::ST_OK) begin
          result_o.format_tag        = fmt_fields_d[15:0];
          result_o.num_channels      = fmt_fields_d[31:16];
          result_o.block_align       = fmt_fields_d[47:32];
          result_o.bits_per_sample   = fmt_fields_d[63:48];
          result_o.sample_rate       = fmt_rates_d[31:0];
          result_o.avg_bytes_per_sec = fmt_rates_d[63:32];
          result_o.data_offset       = data_info_d[31:0];
          result_o.data_size         = data_info_d[63:32];
        end
        // the next byte starts a new file
        phase_d      = PH_RIFF;
        cnt_d        = '0;
        pos_d        = '0;
        skip_d       = '0;
        id_d         = '0;
        size_d       = '0;
        fmt_fields_d = '0;
        fmt_rates_d  = '0;
        data_info_d  = '0;
        err_d        = wcp_pkg::ST_OK;
      end
    end
  end

  assign result_valid_o = item_valid_i && item_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_RIFF;
      cnt_q        <= '0;
      pos_q        <= '0;
      skip_q       <= '0;
      id_q         <= '0;
      size_q       <= '0;
      fmt_fields_q <= '0;
      fmt_rates_q  <= '0;
      data_info_q  <= '0;
      err_q        <= wcp_pkg::ST_OK;
    end else begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      skip_q       <= skip_d;
      id_q         <= id_d;
      size_q       <= size_d;
      fmt_fields_q <= fmt_fields_d;
      fmt_rates_q  <= fmt_rates_d;
      data_info_q  <= data_info_d;
      err_q        <= err_d;
    end
  end

  `ASSERT_PROP(a_hdr_cnt, clk_i, rst_ni, (phase_q == PH_HEADER) |-> (cnt_q <= 4'd7), "header byte count out of range")
  `ASSERT_PROP(a_skip_nz, clk_i, rst_ni, (phase_q == PH_SKIP) |-> (skip_q != '0), "skip phase with nothing to skip")
  `ASSERT_PROP(a_err_code, clk_i, rst_ni, (phase_q == PH_ERROR) |-> (err_q == wcp_pkg::ST_NO_RIFF || err_q == wcp_pkg::ST_NOT_WAVE), "error phase without header error code")
  `ASSERT_PROP(a_restart, clk_i, rst_ni, (item_valid_i && item_i.last) |=> (phase_q == PH_RIFF && pos_q == '0 && cnt_q == '0), "parser did not restart after final byte")

endmodule

`default_nettype wire

/* design/wcp_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wcp_out_stage (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire wcp_pkg::wcp_result_t            result_i,
  output logic                                 out_free_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] status, [17:2] format_tag, [33:18] num_channels, [65:34] sample_rate,
  // [97:66] avg_bytes_per_sec, [113:98] block_align, [129:114] bits_per_sample,
  // [161:130] data_offset, [193:162] data_size, [199:194] zero
  output logic [wcp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic                 valid_q, valid_d;
  wcp_pkg::wcp_result_t res_q;

  assign out_free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'b0, res_q.data_size, res_q.data_offset, res_q.bits_per_sample,
                          res_q.block_align, res_q.avg_bytes_per_sec, res_q.sample_rate,
                          res_q.num_channels, res_q.format_tag, res_q.status};

  `ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, load_i && valid_q && !m_axis_tready, "result register overwritten while held")
  `ASSERT_PROP(a_err_zero, clk_i, rst_ni, (valid_q && res_q.status != wcp_pkg::ST_OK) |-> (res_q.format_tag == '0 && res_q.data_offset == '0 && res_q.data_size == '0), "fields not cleared on error status")

endmodule

`default_nettype wire

/* design/wav_chunk_header_parser.sv */
// A final byte is accepted into the input register; its result is then loaded
// into the result register.
// Throughput: one byte per cycle; a final byte waits only while an earlier
// result is still held in the output register.
// Reset (rst_ni low, asynchronous) returns the parser to the start of a file;
// the same happens after every final byte.
`timescale 1ns / 1ps
`default_nettype none

module wav_chunk_header_parser #(
  parameter int unsigned POSITION_WIDTH = wcp_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [wcp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] file_byte
  input  wire logic                             s_axis_tlast,  // is_last
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [1:0] status, [17:2] format_tag, [33:18] num_channels, [65:34] sample_rate,
  // [97:66] avg_bytes_per_sec, [113:98] block_align, [129:114] bits_per_sample,
  // [161:130] data_offset, [193:162] data_size, [199:194] zero
  output logic [wcp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  logic                 out_free;
  logic                 item_valid;
  wcp_pkg::wcp_item_t   item;
  logic                 result_valid;
  wcp_pkg::wcp_result_t result;

  wcp_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .out_free_i    (out_free),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  wcp_parser #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  wcp_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (result_valid),
    .result_i      (result),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import wcp_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_BYTES = 310;
  localparam int unsigned RANDOM_FILES = 6;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [2:0] {PH_RIFF, PH_HEADER, PH_FMT, PH_SKIP, PH_ERROR} parse_phase_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {
    F_SHORT, F_BAD_RIFF, F_BAD_WAVE, F_HDR_ONLY, F_BASIC, F_FMT_FILL, F_FMT_LONG,
    F_FMT_SHORT, F_FMT_CUT, F_HDR_CUT, F_REPEAT, F_EMPTY_DATA, F_HUGE_DATA
  } file_kind_e;

  typedef struct {
    file_kind_e  kind;
    logic [31:0] arg;
    bit          typed;   // status known up front, every other field zero
    logic [1:0]  status;
  } file_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  wav_chunk_header_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] file_byte
    .s_axis_tlast  (s_axis_tlast),   // is_last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [1:0] status, [17:2] format_tag, [33:18] num_channels, [65:34] sample_rate,
    // [97:66] avg_bytes_per_sec, [113:98] block_align, [129:114] bits_per_sample,
    // [161:130] data_offset, [193:162] data_size, [199:194] zero
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Parser shadow state
  parse_phase_e phase;
  logic [31:0]  byte_pos;
  logic [3:0]   field_cnt;
  logic [31:0]  skip_left;
  logic [31:0]  chunk_id_w;
  logic [31:0]  chunk_len_w;
  logic [63:0]  fmt_word;    // tag, channels, align, bits
  logic [63:0]  rate_word;   // sample rate, byte rate
  logic [31:0]  data_off;
  logic [31:0]  data_len;
  logic [1:0]   err_status;

  wcp_result_t  pending_headers[$];
  logic [7:0]   file_q[$];
  idle_mode_e   idle_mode = IDLE_NONE;
  int unsigned  mismatches = 0;
  int unsigned  file_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  stuck_cycles = 0;

  file_row_t directed_rows[18] = '{
    '{F_SHORT,      1,  1'b1, ST_SHORT},
    '{F_SHORT,      11, 1'b1, ST_SHORT},
    '{F_BAD_RIFF,   0,  1'b1, ST_NO_RIFF},
    '{F_BAD_RIFF,   9,  1'b1, ST_NO_RIFF},
    '{F_BAD_WAVE,   0,  1'b1, ST_NOT_WAVE},
    '{F_BAD_WAVE,   20, 1'b1, ST_NOT_WAVE},
    '{F_HDR_ONLY,   0,  1'b1, ST_OK},
    '{F_BASIC,      4,  1'b0, ST_OK},
    '{F_FMT_FILL,   0,  1'b0, ST_OK},
    '{F_FMT_FILL,   255, 1'b0, ST_OK},
    '{F_FMT_LONG,   6,  1'b0, ST_OK},
    '{F_FMT_SHORT,  0,  1'b0, ST_OK},
    '{F_FMT_SHORT,  15, 1'b0, ST_OK},
    '{F_FMT_CUT,    7,  1'b0, ST_OK},
    '{F_HDR_CUT,    5,  1'b0, ST_OK},
    '{F_REPEAT,     0,  1'b0, ST_OK},
    '{F_EMPTY_DATA, 0,  1'b0, ST_OK},
    '{F_HUGE_DATA,  3,  1'b0, ST_OK}
  };

  task automatic reset_parser();
    phase       = PH_RIFF;
    byte_pos    = '0;
    field_cnt   = '0;
    skip_left   = '0;
    chunk_id_w  = '0;
    chunk_len_w = '0;
    fmt_word    = '0;
    rate_word   = '0;
    data_off    = '0;
    data_len    = '0;
    err_status  = ST_OK;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst,
                            output bit got, output wcp_result_t res);
    int unsigned k;
    int unsigned sh;
    k   = field_cnt;
    sh  = (k % 4) * 8;
    got = 1'b0;
    res = '0;
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    case (phase)
      PH_RIFF: begin
        if (k < 4) chunk_id_w[sh +: 8] = b;
        else if (k >= 8) chunk_len_w[sh +: 8] = b;
        if (k == 11) begin
          if (chunk_id_w != ID_RIFF) begin
            err_status = ST_NO_RIFF;
            phase = PH_ERROR;
          end else if (chunk_len_w != TYPE_WAVE) begin
            err_status = ST_NOT_WAVE;
            phase = PH_ERROR;
          end else begin
            phase = PH_HEADER;
          end
          field_cnt = '0;
        end else begin
          field_cnt = k + 1;
        end
      end
      PH_HEADER: begin
        if (k < 4) chunk_id_w[sh +: 8] = b;
        else chunk_len_w[sh +: 8] = b;
        if (k >= 7) begin
          field_cnt = '0;
          if (chunk_id_w == ID_FMT) begin
            fmt_word  = '0;
            rate_word = '0;
            skip_left = (chunk_len_w > FMT_BODY_LEN) ? chunk_len_w - FMT_BODY_LEN : '0;
            phase     = PH_FMT;
          end else begin
            if (chunk_id_w == ID_DATA) begin
              data_off = byte_pos;
              data_len = chunk_len_w;
            end
            skip_left = chunk_len_w;
            phase     = (skip_left != 0) ? PH_SKIP : PH_HEADER;
          end
        end else begin
          field_cnt = k + 1;
        end
      end
      PH_FMT: begin
        if (k < 4) fmt_word[k*8 +: 8] = b;
        else if (k < 12) rate_word[(k-4)*8 +: 8] = b;
        else fmt_word[(k-8)*8 +: 8] = b;
        if (k >= 15) begin
          field_cnt = '0;
          phase     = (skip_left != 0) ? PH_SKIP : PH_HEADER;
        end else begin
          field_cnt = k + 1;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          field_cnt = '0;
          phase     = PH_HEADER;
        end
      end
      default: ;
    endcase

    if (lst) begin
      got = 1'b1;
      res.status = (phase == PH_RIFF) ? ST_SHORT : err_status;
      if (res.status == ST_OK) begin
        res.format_tag        = fmt_word[15:0];
        res.num_channels      = fmt_word[31:16];
        res.block_align       = fmt_word[47:32];
        res.bits_per_sample   = fmt_word[63:48];
        res.sample_rate       = rate_word[31:0];
        res.avg_bytes_per_sec = rate_word[63:32];
        res.data_offset       = data_off;
        res.data_size         = data_len;
      end
      reset_parser();
    end
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 81;
      IDLE_BOTH:   return $urandom_range(99) < 15;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 81;
      IDLE_BOTH:     return $urandom_range(99) < 15;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic void push_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[i*8 +: 8]);
  endfunction

  function automatic void push_rand(int unsigned n);
    for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
  endfunction

  function automatic void push_riff();
    push_word(ID_RIFF);
    push_word($urandom);
    push_word(TYPE_WAVE);
  endfunction

  function automatic void push_chunk(logic [31:0] id, logic [31:0] len, int unsigned body);
    push_word(id);
    push_word(len);
    push_rand(body);
  endfunction

  function automatic void corrupt_byte(int unsigned idx);
    file_q[idx] = file_q[idx] ^ 8'($urandom_range(255, 1));
  endfunction

  function automatic void build_file(file_kind_e kind, logic [31:0] arg);
    file_q.delete();
    case (kind)
      F_SHORT: push_rand(arg);
      F_BAD_RIFF: begin
        push_riff();
        corrupt_byte($urandom_range(3));
        push_rand(arg);
      end
      F_BAD_WAVE: begin
        push_riff();
        corrupt_byte(8 + $urandom_range(3));
        push_rand(arg);
      end
      F_HDR_ONLY: push_riff();
      F_BASIC: begin
        push_riff();
        push_chunk(ID_FMT, FMT_BODY_LEN, 16);
        push_chunk(32'h5453_494C, arg, arg);   // unknown chunk, skipped
        push_chunk(ID_DATA, arg, arg);
      end
      F_FMT_FILL: begin
        push_riff();
        push_word(ID_FMT);
        push_word(FMT_BODY_LEN);
        for (int i = 0; i < 16; i++) file_q.push_back(arg[7:0]);
        push_word(ID_DATA);
        push_word({4{arg[7:0]}});
        push_rand(2);
      end
      F_FMT_LONG: begin
        push_riff();
        push_chunk(ID_FMT, FMT_BODY_LEN + arg, 16 + arg);
        push_chunk(ID_DATA, 3, 3);
      end
      F_FMT_SHORT: begin
        // body is captured at full length whatever the declared size
        push_riff();
        push_chunk(ID_FMT, arg, 16);
        push_chunk(ID_DATA, 2, 2);
      end
      F_FMT_CUT: begin
        push_riff();
        push_chunk(ID_FMT, FMT_BODY_LEN, arg);
      end
      F_HDR_CUT: begin
        push_riff();
        push_chunk(ID_FMT, FMT_BODY_LEN, 16);
        push_rand(arg);
      end
      F_REPEAT: begin
        push_riff();
        push_chunk(ID_FMT, FMT_BODY_LEN, 16);
        push_chunk(ID_DATA, 2, 2);
        push_chunk(ID_FMT, FMT_BODY_LEN, 16);
        push_chunk(ID_DATA, 3, 3);
      end
      F_EMPTY_DATA: begin
        push_riff();
        push_chunk(ID_DATA, 0, 0);
        push_chunk(ID_FMT, FMT_BODY_LEN, 16);
      end
      F_HUGE_DATA: begin
        push_riff();
        push_chunk(ID_FMT, FMT_BODY_LEN, 16);
        push_chunk(ID_DATA, 32'hFFFF_FFFF, arg);
      end
      default: ;
    endcase
  endfunction

  function automatic void build_random_file();
    int unsigned r;
    int unsigned n;
    int unsigned body;
    int unsigned cut;
    logic [31:0] id;
    logic [31:0] len;
    file_q.delete();
    r = $urandom_range(99);
    if (r < 75) begin
      push_riff();
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(2))
          0: begin
            id = ID_FMT;
            r  = $urandom_range(9);
            if (r < 6) len = FMT_BODY_LEN;
            else if (r < 8) len = FMT_BODY_LEN + $urandom_range(6);
            else len = $urandom_range(15);
            body = (len < 16) ? 16 : len;
          end
          1: begin
            id   = ID_DATA;
            len  = $urandom_range(10);
            body = len;
          end
          default: begin
            id   = $urandom;
            len  = $urandom_range(8);
            body = len;
          end
        endcase
        // final chunk may declare a wide size and be cut short by the end of file
        if (i == n - 1 && $urandom_range(4) == 0) begin
          len  = $urandom;
          body = ((id == ID_FMT) ? 16 : 0) + $urandom_range(3);
        end
        push_chunk(id, len, body);
      end
      if ($urandom_range(3) == 0) begin
        cut = $urandom_range(file_q.size() - 1, 1);
        file_q = file_q[0:cut-1];
      end
    end else if (r < 85) begin
      push_riff();
      corrupt_byte($urandom_range(1) ? $urandom_range(3) : 8 + $urandom_range(3));
      push_rand($urandom_range(20));
    end else if (r < 92) begin
      push_rand($urandom_range(11, 1));
    end else begin
      push_rand($urandom_range(40, 12));
    end
  endfunction

  task automatic send_file(input bit typed, input logic [1:0] st);
    logic [7:0]  b;
    logic        lst;
    bit          got;
    wcp_result_t hdr;
    idle_mode = idle_mode_e'((file_count / 5) % 4);
    foreach (file_q[i]) begin
      b   = file_q[i];
      lst = (i == file_q.size() - 1);
      while (sender_gap()) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= b;
      s_axis_tlast  <= lst;
      do @(posedge clk_i); while (!s_axis_tready);
      parse_byte(b, lst, got, hdr);
      if (got) begin
        if (typed) begin
          hdr = '0;
          hdr.status = st;
        end
        pending_headers.push_back(hdr);
      end
    end
    file_count++;
    bytes_sent += file_q.size();
  endtask

  always @(posedge clk_i) m_axis_tready <= !receiver_stall();

  always @(posedge clk_i) begin
    wcp_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_headers.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        exp_r = pending_headers.pop_front();
        check_field("status",            exp_r.status,            m_axis_tdata[1:0]);
        check_field("format_tag",        exp_r.format_tag,        m_axis_tdata[17:2]);
        check_field("num_channels",      exp_r.num_channels,      m_axis_tdata[33:18]);
        check_field("sample_rate",       exp_r.sample_rate,       m_axis_tdata[65:34]);
        check_field("avg_bytes_per_sec", exp_r.avg_bytes_per_sec, m_axis_tdata[97:66]);
        check_field("block_align",       exp_r.block_align,       m_axis_tdata[113:98]);
        check_field("bits_per_sample",   exp_r.bits_per_sample,   m_axis_tdata[129:114]);
        check_field("data_offset",       exp_r.data_offset,       m_axis_tdata[161:130]);
        check_field("data_size",         exp_r.data_size,         m_axis_tdata[193:162]);
      end
    end
  end

  // cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned first_random_file;
    int unsigned first_random_byte;
    reset_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      build_file(directed_rows[i].kind, directed_rows[i].arg);
      send_file(directed_rows[i].typed, directed_rows[i].status);
    end

    first_random_file = file_count;
    first_random_byte = bytes_sent;
    while (bytes_sent - first_random_byte < RANDOM_BYTES ||
           file_count - first_random_file < RANDOM_FILES) begin
      build_random_file();
      send_file(1'b0, ST_OK);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_headers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
